>>> rtl/core/icy_metadata_deframer_assert.svh
// Assertion macros for the ICY metadata deframer.
// Each macro expects signals named clk and rst in the including scope.
`ifndef ICY_METADATA_DEFRAMER_ASSERT_SVH
`define ICY_METADATA_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ICY_ASSERT_IMPLY(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ICY_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> rtl/core/icy_md_pkg.sv
`default_nettype none

package icy_md_pkg;

  // Widths
  localparam int INTERVAL_BITS = 20;
  localparam int META_BITS     = 12;
  localparam int HIST_DEPTH    = 13;
  localparam int START_LEN     = 13;
  localparam int END_LEN       = 8;
  localparam int TDATA_BITS    = 40;

  localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = INTERVAL_BITS'(16000);

  // Byte history, entry 0 is the newest byte
  typedef logic [HIST_DEPTH-1:0][7:0] hist_t;

  // Markers laid out as they appear in the history (last char in entry 0)
  localparam logic [START_LEN*8-1:0] START_PAT = "StreamTitle='";
  localparam logic [END_LEN*8-1:0]   END_PAT   = "';Stream";
  localparam logic [7:0]             QUOTE     = 8'h27;

  typedef enum logic [1:0] {
    KIND_AUDIO  = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_META   = 2'd2
  } byte_kind_t;

  // Control from the framing logic to the title search
  typedef struct packed {
    logic                 step;
    logic                 clear;
    logic [7:0]           data;
    logic [META_BITS-1:0] pos;
  } search_ctl_t;

  // Title result as it stands after the current byte
  typedef struct packed {
    logic                 found;
    logic [META_BITS-1:0] offset;
    logic [META_BITS-1:0] length;
  } search_res_t;

  // One result item
  typedef struct packed {
    byte_kind_t           kind;
    logic [7:0]           value;
    logic                 done;
    logic                 found;
    logic [META_BITS-1:0] offset;
    logic [META_BITS-1:0] length;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/icy_md_title_search.sv
`default_nettype none

module icy_md_title_search (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire icy_md_pkg::search_ctl_t ctl,
  output icy_md_pkg::search_res_t      res
);

  icy_md_pkg::hist_t                 hist, hist_next;
  logic                              start_seen, start_seen_next;
  logic [icy_md_pkg::META_BITS-1:0]  start_pos, start_pos_next;
  logic                              end_seen, end_seen_next;
  logic [icy_md_pkg::META_BITS-1:0]  end_pos, end_pos_next;
  logic                              quote_seen, quote_seen_next;
  logic [icy_md_pkg::META_BITS-1:0]  quote_pos, quote_pos_next;
  logic                              zero_seen, zero_seen_next;

  logic [icy_md_pkg::META_BITS:0]    pos_plus1;
  logic [icy_md_pkg::META_BITS:0]    end_limit;
  logic                              start_hit, end_hit;
  logic                              have_stop;
  logic [icy_md_pkg::META_BITS-1:0]  stop_pos;

  // Shifted history and marker compares for the incoming byte
  always_comb begin
    hist_next    = {hist[icy_md_pkg::HIST_DEPTH-2:0], ctl.data};
    pos_plus1    = {1'b0, ctl.pos} + 1'b1;
    end_limit    = {1'b0, start_pos} + (icy_md_pkg::META_BITS+1)'(icy_md_pkg::END_LEN);
    start_hit    = (hist_next == icy_md_pkg::START_PAT) &&
                   (pos_plus1 >= (icy_md_pkg::META_BITS+1)'(icy_md_pkg::START_LEN));
    end_hit      = (hist_next[icy_md_pkg::END_LEN-1:0] == icy_md_pkg::END_PAT) &&
                   (pos_plus1 >= end_limit);
  end

  // Next search state
  always_comb begin
    start_seen_next = start_seen;
    start_pos_next  = start_pos;
    end_seen_next   = end_seen;
    end_pos_next    = end_pos;
    quote_seen_next = quote_seen;
    quote_pos_next  = quote_pos;
    zero_seen_next  = zero_seen;
    if (ctl.step && !zero_seen) begin
      if (ctl.data == 8'h00) begin
        zero_seen_next = 1'b1;
      end else if (start_seen) begin
        if (!end_seen && end_hit) begin
          end_seen_next = 1'b1;
          end_pos_next  = ctl.pos - icy_md_pkg::META_BITS'(icy_md_pkg::END_LEN - 1);
        end
        if (ctl.data == icy_md_pkg::QUOTE) begin
          quote_seen_next = 1'b1;
          quote_pos_next  = ctl.pos;
        end
      end else if (start_hit) begin
        start_seen_next = 1'b1;
        start_pos_next  = pos_plus1[icy_md_pkg::META_BITS-1:0];
      end
    end
  end

  // Title result from the updated state
  always_comb begin
    have_stop  = 1'b0;
    stop_pos   = '0;
    res        = '0;
    priority if (start_seen_next && end_seen_next) begin
      have_stop = 1'b1;
      stop_pos  = end_pos_next;
    end else if (start_seen_next && quote_seen_next) begin
      have_stop = 1'b1;
      stop_pos  = quote_pos_next;
    end else begin
      have_stop = 1'b0;
      stop_pos  = '0;
    end
    if (have_stop && (stop_pos >= start_pos_next)) begin
      res.found  = 1'b1;
      res.offset = start_pos_next;
      res.length = stop_pos - start_pos_next;
    end
  end

  // Hold search state; clear it on a length byte
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hist       <= '0;
      start_seen <= 1'b0;
      start_pos  <= '0;
      end_seen   <= 1'b0;
      end_pos    <= '0;
      quote_seen <= 1'b0;
      quote_pos  <= '0;
      zero_seen  <= 1'b0;
    end else begin
      if (ctl.step && !zero_seen && (ctl.data != 8'h00)) begin
        hist <= hist_next;
      end
      start_seen <= start_seen_next;
      start_pos  <= start_pos_next;
      end_seen   <= end_seen_next;
      end_pos    <= end_pos_next;
      quote_seen <= quote_seen_next;
      quote_pos  <= quote_pos_next;
      zero_seen  <= zero_seen_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/icy_metadata_deframer.sv
// Channel   Dir  tdata (low bit up)                           tuser       tlast
// s_axis    in   stream_byte[7:0]                             -           chunk_last
// m_axis    out  byte_value, title_found, title_offset,       byte_kind   meta_done
//                title_length, zero pad to 40 bits
// cfg       in   cfg_wdata = meta_interval (cfg_we strobes a write)
//
// One item per cycle: each byte is classified and searched in the cycle it is
// accepted and its result sits in the output register on the next edge.
// Throughput is set by the single output register; s_axis_tready drops only
// while that register holds an item the sink has not taken.
// rst is synchronous: meta_interval returns to 16000, audio count reloads,
// search state and the output valid flag clear.
`default_nettype none

`include "icy_metadata_deframer_assert.svh"

module icy_metadata_deframer (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [icy_md_pkg::INTERVAL_BITS-1:0] cfg_wdata,
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  input  wire logic [7:0]                           s_axis_tdata,  // stream_byte
  input  wire logic                                 s_axis_tlast,  // chunk_last
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // byte_value[7:0], title_found[8], title_offset[20:9], title_length[32:21]
  output      logic [icy_md_pkg::TDATA_BITS-1:0]    m_axis_tdata,
  output      logic [1:0]                           m_axis_tuser,  // byte_kind
  output      logic                                 m_axis_tlast   // meta_done
);

  logic [icy_md_pkg::INTERVAL_BITS-1:0] meta_interval;
  logic [icy_md_pkg::INTERVAL_BITS-1:0] audio_left, audio_left_next;
  logic                                 in_meta, in_meta_next;
  logic [icy_md_pkg::META_BITS-1:0]     meta_length, meta_length_next;
  logic [icy_md_pkg::META_BITS-1:0]     meta_position, meta_position_next;

  logic                                 accept;
  logic                                 len_byte;
  icy_md_pkg::search_ctl_t              search_ctl;
  icy_md_pkg::search_res_t              search_res;
  icy_md_pkg::out_item_t                item_next, out_item;
  logic                                 out_valid;

  // Chunk boundaries carry no meaning for the deframer
  logic                                 chunk_last_unused;
  assign chunk_last_unused = s_axis_tlast;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign len_byte      = !in_meta && (audio_left == '0);

  // Drive the title search
  always_comb begin
    search_ctl.step  = accept && in_meta;
    search_ctl.clear = accept && len_byte && !chunk_last_unused
                       || accept && len_byte && chunk_last_unused;
    search_ctl.data  = s_axis_tdata;
    search_ctl.pos   = meta_position;
  end

  icy_md_title_search u_search (
    .clk (clk),
    .rst (rst),
    .ctl (search_ctl),
    .res (search_res)
  );

  // Classify the byte and advance framing counters
  always_comb begin
    audio_left_next    = audio_left;
    in_meta_next       = in_meta;
    meta_length_next   = meta_length;
    meta_position_next = meta_position;
    item_next          = '0;
    item_next.value    = s_axis_tdata;
    priority if (in_meta) begin
      item_next.kind     = icy_md_pkg::KIND_META;
      meta_position_next = meta_position + 1'b1;
      if (meta_position_next >= meta_length) begin
        item_next.done   = 1'b1;
        item_next.found  = search_res.found;
        item_next.offset = search_res.offset;
        item_next.length = search_res.length;
        in_meta_next     = 1'b0;
        audio_left_next  = meta_interval;
      end
    end else if (len_byte) begin
      item_next.kind     = icy_md_pkg::KIND_LENGTH;
      meta_length_next   = {s_axis_tdata, 4'h0};
      meta_position_next = '0;
      if (s_axis_tdata != 8'h00) begin
        in_meta_next = 1'b1;
      end else begin
        audio_left_next = meta_interval;
      end
    end else begin
      item_next.kind  = icy_md_pkg::KIND_AUDIO;
      audio_left_next = audio_left - 1'b1;
    end
  end

  // Framing state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_interval <= icy_md_pkg::INTERVAL_RESET;
      audio_left    <= icy_md_pkg::INTERVAL_RESET;
      in_meta       <= 1'b0;
      meta_length   <= '0;
      meta_position <= '0;
    end else if (cfg_we) begin
      meta_interval <= cfg_wdata;
      audio_left    <= cfg_wdata;
    end else if (accept) begin
      audio_left    <= audio_left_next;
      in_meta       <= in_meta_next;
      meta_length   <= meta_length_next;
      meta_position <= meta_position_next;
    end
  end

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= item_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_item.kind;
  assign m_axis_tlast  = out_item.done;
  assign m_axis_tdata  = {7'h00, out_item.length, out_item.offset,
                          out_item.found, out_item.value};

  // Checks
  `ICY_ASSERT_IMPLY(a_done_on_meta, m_axis_tvalid && m_axis_tlast,
                    m_axis_tuser == icy_md_pkg::KIND_META,
                    "block end flagged on a non-metadata byte")
  `ICY_ASSERT_IMPLY(a_found_needs_done, m_axis_tvalid && !m_axis_tlast,
                    m_axis_tdata[8] == 1'b0,
                    "title reported outside block end")
  `ICY_ASSERT_IMPLY(a_meta_nonempty, in_meta, meta_length != '0,
                    "metadata phase with zero length")
  `ICY_ASSERT_NEXT(a_len_enters_meta, accept && len_byte && !cfg_we &&
                   (s_axis_tdata != 8'h00), in_meta,
                   "nonzero length byte did not open a block")

endmodule

`default_nettype wire
